// ----- sv/sha_pkg.sv -----
// sha_pkg: shared types, constants and the round constant table for the SHA-256 hasher.
// No dependencies; imported by every module of the block.
package sha_pkg;

	// Working variables and chaining value: word 0 is a (H0), word 7 is h (H7).
	typedef logic [0:7][31:0] work_t;

	localparam work_t IV = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam int unsigned CountW = 61;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned FillW = $clog2(BlockBytes);
	localparam int unsigned Rounds = 64;
	localparam int unsigned RoundW = $clog2(Rounds);
	localparam int unsigned DigestWords = 8;
	localparam int unsigned IdxW = $clog2(DigestWords);
	localparam logic [FillW-1:0] LenPos = FillW'(56);
	localparam logic [7:0] PadMark = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0]     digest_word;
		logic [IdxW-1:0] word_index;
		logic            last_word;
	} dig_t;

	// Message schedule taps for one round: W[t], W[t+1], W[t+9], W[t+14].
	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w9;
		logic [31:0] w14;
	} taps_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ROUND  = 5'b00010,
		ST_FINISH = 5'b00100,
		ST_PAD    = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	function automatic logic [31:0] round_k(input logic [RoundW-1:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ----- sv/sha256_message_hash.sv -----
// sha256_message_hash: byte-serial SHA-256 hasher, top level with sequencer and state.
// Depends on sha_pkg and sha_rnd.
//
// Usage:
//  - Request channel msg (msg_valid/msg_ready): one byte per request, with
//    byte_present and end_of_message flags. Requests with neither flag are
//    accepted and dropped. An end request without a byte closes the message.
//  - Result channel dig (dig_valid/dig_ready): eight digest words, index 0
//    first, last_word set on index 7. The block then starts a new message.
//  - Throughput: a byte is taken each cycle while the 64-byte block fills.
//    The 64th byte starts a compression: 64 rounds through one shared round
//    unit, one round a cycle, then a fold into the chaining value; msg_ready
//    stays low until the fold is done.
//  - End of message: padding bytes are shifted in one a cycle until the block
//    is full, then the block is compressed. A tail of 56 bytes or more spills
//    into a second block, which is padded and compressed the same way. Then
//    the eight words, one a cycle when dig_ready is held high.
//  - A stalled receiver simply holds the block in its output phase; msg_ready
//    stays low until the last word is taken.
//  - Reset (arst_n low) loads the initial hash values and clears the length.
module sha256_message_hash (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_ready,
	input  sha_pkg::msg_t msg,
	output logic          dig_valid,
	input  logic          dig_ready,
	output sha_pkg::dig_t dig
);
	import sha_pkg::*;

	state_t                 state_q;
	logic [BlockBytes*8-1:0] blk_q;      // 64-byte block, doubles as schedule window
	work_t                  h_q;        // chaining value
	work_t                  v_q;        // working variables a..h
	logic [CountW-1:0]      count_q;    // message length in bytes, wraps
	logic [FillW-1:0]       fill_q;     // bytes in the current block
	logic [RoundW-1:0]      rnd_q;
	logic [IdxW-1:0]        idx_q;
	logic                   pad_mode_q; // end seen, padding in progress
	logic                   first_q;    // pad marker byte still to be written
	logic                   len_ok_q;   // this block carries the length field
	logic                   final_q;    // block under compression is the last one

	taps_t       taps;
	work_t       v_nxt;
	logic [31:0] w_new;
	logic [63:0] len_bits;
	logic [63:0] len_sh;
	logic [7:0]  pad_byte;
	logic        msg_acc;
	logic        dig_acc;

	// Schedule taps straight off the shifting block: word j sits at the j-th
	// 32-bit slot from the top.
	assign taps.w0  = blk_q[BlockBytes*8-1 -: 32];
	assign taps.w1  = blk_q[BlockBytes*8-1-32 -: 32];
	assign taps.w9  = blk_q[BlockBytes*8-1-9*32 -: 32];
	assign taps.w14 = blk_q[BlockBytes*8-1-14*32 -: 32];

	sha_rnd u_rnd (
		.v     (v_q),
		.taps  (taps),
		.k     (round_k(rnd_q)),
		.v_nxt (v_nxt),
		.w_new (w_new)
	);

	// Length field bytes go out most significant first at positions 56..63.
	assign len_bits = {count_q, 3'b000};
	assign len_sh   = len_bits >> {~fill_q[2:0], 3'b000};

	always_comb begin
		if (first_q) begin
			pad_byte = PadMark;
		end else if (len_ok_q && (fill_q >= LenPos)) begin
			pad_byte = len_sh[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign msg_ready = (state_q == ST_IDLE);
	assign msg_acc   = msg_valid && msg_ready;
	assign dig_valid = (state_q == ST_OUT);
	assign dig_acc   = dig_valid && dig_ready;

	assign dig.digest_word = h_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == IdxW'(DigestWords - 1));

	// Payload registers: block buffer and working variables.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (msg_acc && msg.byte_present) begin
					blk_q <= {blk_q[BlockBytes*8-9:0], msg.data_byte};
				end
				v_q <= h_q;
			end
			ST_PAD: begin
				blk_q <= {blk_q[BlockBytes*8-9:0], pad_byte};
				v_q   <= h_q;
			end
			ST_ROUND: begin
				blk_q <= {blk_q[BlockBytes*8-33:0], w_new};
				v_q   <= v_nxt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			h_q        <= IV;
			count_q    <= '0;
			fill_q     <= '0;
			rnd_q      <= '0;
			idx_q      <= '0;
			pad_mode_q <= 1'b0;
			first_q    <= 1'b0;
			len_ok_q   <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.byte_present) begin
							fill_q  <= fill_q + 1'b1;
							count_q <= count_q + 1'b1;
						end
						if (msg.end_of_message) begin
							pad_mode_q <= 1'b1;
							first_q    <= 1'b1;
							len_ok_q   <= 1'b0;
						end
						if (msg.byte_present && (fill_q == FillW'(BlockBytes - 1))) begin
							rnd_q   <= '0;
							final_q <= 1'b0;
							state_q <= ST_ROUND;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q  <= fill_q + 1'b1;
					first_q <= 1'b0;
					if (first_q && (fill_q < LenPos)) begin
						len_ok_q <= 1'b1;
					end
					if (fill_q == FillW'(BlockBytes - 1)) begin
						// a spilled block is always followed by the length block
						final_q  <= len_ok_q;
						len_ok_q <= 1'b1;
						rnd_q    <= '0;
						state_q  <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RoundW'(Rounds - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					for (int i = 0; i < DigestWords; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (!pad_mode_q) begin
						state_q <= ST_IDLE;
					end else if (final_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == IdxW'(DigestWords - 1)) begin
							h_q        <= IV;
							count_q    <= '0;
							fill_q     <= '0;
							pad_mode_q <= 1'b0;
							final_q    <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/sha_rnd.sv -----
// sha_rnd: one SHA-256 compression round plus the next message schedule word.
// Depends on sha_pkg.
module sha_rnd (
	input  sha_pkg::work_t v,
	input  sha_pkg::taps_t taps,
	input  logic [31:0]    k,
	output sha_pkg::work_t v_nxt,
	output logic [31:0]    w_new
);
	import sha_pkg::*;

	logic [31:0] a, e, s0_big, s1_big, ch, maj, t1, t2, s0_sm, s1_sm;

	always_comb begin
		a      = v[0];
		e      = v[4];
		s1_big = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		s0_big = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		ch     = (e & v[5]) ^ (~e & v[6]);
		maj    = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
		t1     = v[7] + s1_big + ch + k + taps.w0;
		t2     = s0_big + maj;
		v_nxt[0] = t1 + t2;
		v_nxt[1] = v[0];
		v_nxt[2] = v[1];
		v_nxt[3] = v[2];
		v_nxt[4] = v[3] + t1;
		v_nxt[5] = v[4];
		v_nxt[6] = v[5];
		v_nxt[7] = v[6];
		// schedule: sigma0 on W[t+1], sigma1 on W[t+14]
		s0_sm = {taps.w1[6:0], taps.w1[31:7]} ^ {taps.w1[17:0], taps.w1[31:18]}
			^ (taps.w1 >> 3);
		s1_sm = {taps.w14[16:0], taps.w14[31:17]} ^ {taps.w14[18:0], taps.w14[31:19]}
			^ (taps.w14 >> 10);
		w_new = s1_sm + taps.w9 + s0_sm + taps.w0;
	end

endmodule

// ----- sv/sha_chk.sv -----
// sha_chk: port-level checks on the SHA-256 hasher, bound to its top level.
// Depends on sha_pkg and sha256_message_hash.
module sha_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          msg_valid,
	input logic          msg_ready,
	input sha_pkg::msg_t msg,
	input logic          dig_valid,
	input logic          dig_ready,
	input sha_pkg::dig_t dig
);
	import sha_pkg::*;

	// stalled result holds
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig))
		else $error("digest word changed while stalled");

	// no request taken while a digest is pending
	a_no_req_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> !msg_ready)
		else $error("request channel open during digest output");

	// an end request closes the request channel
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg.end_of_message |=> !msg_ready)
		else $error("request channel still open after end of message");

	// words of one digest follow without a gap, in order
	a_word_next: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !dig.last_word |=>
			dig_valid && (dig.word_index == $past(dig.word_index) + 1'b1))
		else $error("digest word sequence broken");

	// the last word returns the block to taking requests
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && dig.last_word |=> !dig_valid && msg_ready)
		else $error("block did not return to idle after last word");

endmodule

bind sha256_message_hash sha_chk u_sha_chk (.*);

// ----- dv/sha256_message_hash_tb.sv -----
// Self-checking testbench for sha256_message_hash: byte-stream messages in, digest words out.
// Depends on sha_pkg (request/result structs) and the sha256_message_hash RTL.
module sha256_message_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sha_pkg::*;

	localparam int RANDOM_ITEMS = 250;
	localparam int MIN_RANDOM_MSGS = 8;
	localparam int CYCLE_LIMIT = 400000;
	// Quiet cycles after the last digest word; well above one padded block.
	localparam int DRAIN_CYCLES = 300;
	localparam int LEN_TAIL_LIMIT = 56;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [0:7][31:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] RND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// All block inputs start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	msg_t msg = '0;
	logic dig_valid;
	logic dig_ready = 1'b0;
	dig_t dig;

	sha256_message_hash uut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg(msg),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig(dig)
	);

	always #5ns clk = ~clk;

	// Requests waiting to be driven, and digest words waiting to come out.
	msg_t pending_requests[$];
	dig_t expected_words[$];

	int total_requests = 0;
	int sent_count = 0;     // requests put on the bus by the driver
	int msg_accepted = 0;   // requests taken by the block
	int errors = 0;
	int cycle_count = 0;
	int phase;

	// Shadow hash state: chaining value, partial block, message length in bytes.
	logic [0:7][31:0]  chain_hv = H_INIT;
	logic [0:63][7:0]  blk_bytes = '0;
	logic [60:0]       msg_bytes = '0;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of a padded or full block into chain_hv.
	task automatic sha_compress(input logic [0:63][7:0] blk);
		logic [31:0] w[0:63];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		{a, b, c, d, e, f, g, h} = chain_hv;
		for (i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ RND_K[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		chain_hv[0] += a;
		chain_hv[1] += b;
		chain_hv[2] += c;
		chain_hv[3] += d;
		chain_hv[4] += e;
		chain_hv[5] += f;
		chain_hv[6] += g;
		chain_hv[7] += h;
	endtask

	// Update the shadow state for one accepted request; an end request
	// queues the eight digest words and restarts the hash.
	task automatic hash_request(input msg_t m);
		logic [0:63][7:0] pad;
		logic [63:0] bit_len;
		dig_t word;
		int tail;
		int i;
		if (m.byte_present) begin
			blk_bytes[msg_bytes[5:0]] = m.data_byte;
			msg_bytes = msg_bytes + 61'd1;
			if (msg_bytes[5:0] == 6'd0)
				sha_compress(blk_bytes);
		end
		if (m.end_of_message) begin
			tail = int'(msg_bytes[5:0]);
			bit_len = {msg_bytes, 3'b000};
			pad = '0;
			for (i = 0; i < tail; i++)
				pad[i] = blk_bytes[i];
			pad[tail] = PAD_MARK;
			// Tail too long for the length field: padding spills into a second block.
			if (tail >= LEN_TAIL_LIMIT) begin
				sha_compress(pad);
				pad = '0;
			end
			for (i = 0; i < 8; i++)
				pad[63-i] = bit_len[8*i +: 8];
			sha_compress(pad);
			for (i = 0; i < 8; i++) begin
				word.digest_word = chain_hv[i];
				word.word_index = IdxW'(i);
				word.last_word = (i == 7);
				expected_words.push_back(word);
			end
			chain_hv = H_INIT;
			msg_bytes = '0;
		end
	endtask

	task automatic push_req(input logic [7:0] data, input logic present, input logic last);
		msg_t m;
		m.data_byte = data;
		m.byte_present = present;
		m.end_of_message = last;
		pending_requests.push_back(m);
	endtask

	// Random message of len bytes; ends either on the last byte or with a
	// separate end request. Stray ignored requests are sprinkled in.
	task automatic queue_message(input int len, output int counted);
		bit end_on_byte;
		int i;
		end_on_byte = (len > 0) && ($urandom_range(1) == 1);
		counted = 0;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 5) begin
				push_req(8'($urandom), 1'b0, 1'b0);
				counted++;
			end
			push_req(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
			counted++;
		end
		if (!end_on_byte) begin
			push_req(8'($urandom), 1'b0, 1'b1);
			counted++;
		end
	endtask

	// Idle phases by progress through the request stream:
	// 0 none, 1 sender gaps, 2 receiver stalls, 3 both lighter.
	always_comb begin
		if (total_requests == 0)
			phase = 0;
		else if (msg_accepted * 4 / total_requests > 3)
			phase = 3;
		else
			phase = msg_accepted * 4 / total_requests;
	end

	// Request driver: changes at the falling edge, holds valid and payload
	// until the monitor has seen the request accepted.
	always @(negedge clk) begin
		int gap_pct;
		case (phase)
			1: gap_pct = 61;
			3: gap_pct = 22;
			default: gap_pct = 0;
		endcase
		if (arst_n && sent_count == msg_accepted) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
				msg <= pending_requests.pop_front();
				msg_valid <= 1'b1;
				sent_count++;
			end else begin
				msg_valid <= 1'b0;
			end
		end
	end

	// Digest receiver back-pressure.
	always @(negedge clk) begin
		int stall_pct;
		case (phase)
			2: stall_pct = 61;
			3: stall_pct = 22;
			default: stall_pct = 0;
		endcase
		if (arst_n)
			dig_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Monitor: both handshakes sampled at the rising edge.
	always @(posedge clk) begin
		dig_t want;
		if (arst_n) begin
			if (msg_valid && msg_ready) begin
				hash_request(msg);
				msg_accepted++;
			end
			if (dig_valid && dig_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected digest word %0d: %h", dig.word_index, dig.digest_word);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (dig.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h",
							want.digest_word, dig.digest_word);
						errors++;
					end
					if (dig.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d",
							want.word_index, dig.word_index);
						errors++;
					end
					if (dig.last_word !== want.last_word) begin
						$error("last_word: expected %0d, got %0d",
							want.last_word, dig.last_word);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int random_items;
		int random_msgs;
		int len;
		int counted;
		int r;

		// Directed: ignored requests at both data extremes, the empty
		// message, a lone byte ending the message, an end request with no
		// byte after data, an ignored request inside a message, two empty
		// messages back to back, and the classic "abc".
		push_req(8'h00, 1'b0, 1'b0);
		push_req(8'hff, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b1);
		push_req(8'hff, 1'b1, 1'b1);
		push_req(8'h00, 1'b1, 1'b0);
		push_req(8'hff, 1'b0, 1'b1);
		push_req(8'h5a, 1'b1, 1'b0);
		push_req(8'hc3, 1'b0, 1'b0);
		push_req(8'ha5, 1'b1, 1'b1);
		push_req(8'hff, 1'b0, 1'b1);
		push_req(8'h00, 1'b0, 1'b1);
		push_req(8'h61, 1'b1, 1'b0);
		push_req(8'h62, 1'b1, 1'b0);
		push_req(8'h63, 1'b1, 1'b1);

		// Random messages: mostly short, a good share right at the padding
		// boundaries, some spanning one or two full blocks.
		random_items = 0;
		random_msgs = 0;
		while (random_items < RANDOM_ITEMS || random_msgs < MIN_RANDOM_MSGS) begin
			r = $urandom_range(99);
			if (r < 55)
				len = $urandom_range(24);
			else if (r < 85) begin
				case ($urandom_range(3))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					default: len = 64;
				endcase
			end else
				len = $urandom_range(130, 65);
			queue_message(len, counted);
			random_items += counted;
			random_msgs++;
		end
		total_requests = pending_requests.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || sent_count != msg_accepted)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
